FILE: design/fpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpc_pkg;

    localparam int TABLE_DEPTH = 64;
    // position counter reaches table depth at the chain end
    localparam int POS_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (POS_W > 6) ? POS_W : 6;

    localparam logic [5:0] SHORT_LIMIT = 6'd33;
    localparam logic [5:0] POS_MAX = 6'd63;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] ST_NEW = 3'd0;
    localparam logic [2:0] ST_HIT = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_SHORT = 3'd3;
    localparam logic [2:0] ST_READ_OK = 3'd4;
    localparam logic [2:0] ST_READ_EMPTY = 3'd5;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] frame_byte;
        logic       frame_last;
        logic [5:0] read_index;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  status;
        logic [5:0]  entry_index;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [31:0] hit_count;
    } t_out_word;

    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } t_cap;

    typedef struct packed {
        logic             vld;
        logic             is_read;
        logic [63:0]      key;
        logic [47:0]      src_mac;
        logic [47:0]      dst_mac;
        logic [5:0]       read_index;
        logic [POS_W-1:0] pos;
        logic             found;
        t_out_word        res;
    } t_token;

endpackage
`default_nettype wire

FILE: design/fpc_capture.sv
`timescale 1ns / 1ps
`default_nettype none
module fpc_capture (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_byte_acc,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    output fpc_pkg::t_cap      o_cap_next,
    output logic               o_short
);

    logic [5:0]    r_pos;
    logic [5:0]    n_pos;
    fpc_pkg::t_cap r_cap;
    fpc_pkg::t_cap n_cap;

    // header field capture, including the byte now offered
    always_comb begin
        n_cap = r_cap;
        if (r_pos < 6'd6) begin
            n_cap.dst_mac = {r_cap.dst_mac[39:0], i_byte};
        end else if (r_pos < 6'd12) begin
            n_cap.src_mac = {r_cap.src_mac[39:0], i_byte};
        end else if (r_pos >= 6'd26 && r_pos < 6'd30) begin
            n_cap.src_ip = {r_cap.src_ip[23:0], i_byte};
        end else if (r_pos >= 6'd30 && r_pos < 6'd34) begin
            n_cap.dst_ip = {r_cap.dst_ip[23:0], i_byte};
        end
    end

    // byte position, saturating, back to zero after the last byte
    always_comb begin
        n_pos = r_pos;
        if (i_last) begin
            n_pos = 6'd0;
        end else if (r_pos != fpc_pkg::POS_MAX) begin
            n_pos = r_pos + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 6'd0;
            r_cap <= '0;
        end else if (i_byte_acc) begin
            r_pos <= n_pos;
            r_cap <= n_cap;
        end
    end

    assign o_cap_next = n_cap;
    assign o_short = (r_pos < fpc_pkg::SHORT_LIMIT);

endmodule
`default_nettype wire

FILE: design/fpc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module fpc_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fpc_pkg::t_token i_tok,
    output fpc_pkg::t_token    o_tok
);

    logic        r_valid;
    logic        n_valid;
    logic [63:0] r_key;
    logic [63:0] n_key;
    logic [47:0] r_smac;
    logic [47:0] n_smac;
    logic [47:0] r_dmac;
    logic [47:0] n_dmac;
    logic [31:0] r_count;
    logic [31:0] n_count;
    fpc_pkg::t_token r_tok;
    fpc_pkg::t_token n_tok;
    logic        idx_match;

    assign idx_match = (fpc_pkg::CMP_W'(i_tok.pos) == fpc_pkg::CMP_W'(i_tok.read_index));

    // slot update and token rewrite as the word passes this cell
    always_comb begin
        n_valid = r_valid;
        n_key = r_key;
        n_smac = r_smac;
        n_dmac = r_dmac;
        n_count = r_count;
        n_tok = i_tok;
        n_tok.pos = i_tok.pos + fpc_pkg::POS_W'(1);
        if (i_tok.vld && !i_tok.found) begin
            if (!i_tok.is_read) begin
                if (r_valid && r_key == i_tok.key) begin
                    if (r_count != fpc_pkg::COUNT_MAX) begin
                        n_count = r_count + 32'd1;
                    end
                    n_tok.found = 1'b1;
                    n_tok.res = {fpc_pkg::KIND_FRAME, fpc_pkg::ST_HIT, 6'(i_tok.pos),
                                 r_smac, r_dmac, r_key[63:32], r_key[31:0], n_count};
                end else if (!r_valid) begin
                    n_valid = 1'b1;
                    n_key = i_tok.key;
                    n_smac = i_tok.src_mac;
                    n_dmac = i_tok.dst_mac;
                    n_count = 32'd1;
                    n_tok.found = 1'b1;
                    n_tok.res = {fpc_pkg::KIND_FRAME, fpc_pkg::ST_NEW, 6'(i_tok.pos),
                                 i_tok.src_mac, i_tok.dst_mac, i_tok.key[63:32],
                                 i_tok.key[31:0], 32'd1};
                end
            end else if (idx_match) begin
                n_tok.found = 1'b1;
                if (r_valid) begin
                    n_tok.res = {fpc_pkg::KIND_READ, fpc_pkg::ST_READ_OK, 6'(i_tok.pos),
                                 r_smac, r_dmac, r_key[63:32], r_key[31:0], r_count};
                end
            end
        end
    end

    // control state and token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok <= n_tok;
        end
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_smac <= n_smac;
        r_dmac <= n_dmac;
        r_count <= n_count;
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

FILE: design/ip_pair_flow_counter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | valid      | ready       | word
// input    | i_in_valid | o_in_ready  | i_in_word  (fpc_pkg::t_in_word)
// output   | o_out_valid| i_out_ready | o_out_word (fpc_pkg::t_out_word)
//
// a frame byte that is not last gives no word; a frame end that is not short
// or a read sends one word down the row of TABLE_DEPTH slot cells, one cell a
// cycle, through the launch register, every cell and the output register
// a short frame is reported from the output register the cycle after its end
// input is held off while a word walks the row and reopens the cycle the result
// appears (to words only with a free output); reset empties every slot at once
module ip_pair_flow_counter_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire fpc_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output fpc_pkg::t_out_word o_out_word
);

    logic               r_busy;
    logic               r_out_valid;
    fpc_pkg::t_out_word r_out;
    fpc_pkg::t_token    r_launch;
    fpc_pkg::t_token    n_launch;
    fpc_pkg::t_token    w_tok [0:fpc_pkg::TABLE_DEPTH];
    fpc_pkg::t_cap      w_cap_next;
    logic               w_short;
    logic               in_acc;
    logic               byte_acc;
    logic               gives_word;
    logic               short_end;
    logic               launch;
    logic               out_free;

    assign out_free = !r_out_valid || i_out_ready;
    assign gives_word = (i_in_word.kind == fpc_pkg::KIND_READ) || i_in_word.frame_last;
    assign o_in_ready = !r_busy && (!gives_word || out_free);
    assign in_acc = i_in_valid && o_in_ready;
    assign byte_acc = in_acc && (i_in_word.kind == fpc_pkg::KIND_FRAME);
    assign short_end = byte_acc && i_in_word.frame_last && w_short;
    assign launch = in_acc && gives_word && !short_end;

    fpc_capture u_capture (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_acc (byte_acc),
        .i_byte     (i_in_word.frame_byte),
        .i_last     (i_in_word.frame_last),
        .o_cap_next (w_cap_next),
        .o_short    (w_short)
    );

    // word entering the row, preloaded with the miss or empty-read answer
    always_comb begin
        n_launch = '0;
        n_launch.vld = launch;
        n_launch.read_index = i_in_word.read_index;
        if (i_in_word.kind == fpc_pkg::KIND_READ) begin
            n_launch.is_read = 1'b1;
            n_launch.res.result_kind = fpc_pkg::KIND_READ;
            n_launch.res.status = fpc_pkg::ST_READ_EMPTY;
            n_launch.res.entry_index = i_in_word.read_index;
        end else begin
            n_launch.key = {w_cap_next.src_ip, w_cap_next.dst_ip};
            n_launch.src_mac = w_cap_next.src_mac;
            n_launch.dst_mac = w_cap_next.dst_mac;
            n_launch.res.result_kind = fpc_pkg::KIND_FRAME;
            n_launch.res.status = fpc_pkg::ST_FULL;
            n_launch.res.src_mac = w_cap_next.src_mac;
            n_launch.res.dst_mac = w_cap_next.dst_mac;
            n_launch.res.src_ip = w_cap_next.src_ip;
            n_launch.res.dst_ip = w_cap_next.dst_ip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= '0;
        end else begin
            r_launch <= n_launch;
        end
    end

    assign w_tok[0] = r_launch;

    // row of slot cells
    genvar g;
    generate
        for (g = 0; g < fpc_pkg::TABLE_DEPTH; g++) begin : g_cell
            fpc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    // busy flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (launch) begin
                r_busy <= 1'b1;
            end else if (w_tok[fpc_pkg::TABLE_DEPTH].vld) begin
                r_busy <= 1'b0;
            end
            if (w_tok[fpc_pkg::TABLE_DEPTH].vld || short_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[fpc_pkg::TABLE_DEPTH].vld) begin
            r_out <= w_tok[fpc_pkg::TABLE_DEPTH].res;
        end else if (short_end) begin
            r_out <= '0;
            r_out.result_kind <= fpc_pkg::KIND_FRAME;
            r_out.status <= fpc_pkg::ST_SHORT;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out;

endmodule
`default_nettype wire

FILE: tb/tb_ip_pair_flow_counter_core.sv
`timescale 1ns / 1ps
module tb_ip_pair_flow_counter_core;

    localparam int DEPTH = fpc_pkg::TABLE_DEPTH;
    localparam int LAT = DEPTH + 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    fpc_pkg::t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    fpc_pkg::t_out_word o_out_word;

    ip_pair_flow_counter_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word(o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // flow table mirror
    logic [5:0]  pos_q;
    logic [47:0] cur_dst_mac, cur_src_mac;
    logic [31:0] cur_src_ip, cur_dst_ip;
    logic        tbl_valid [DEPTH];
    logic [63:0] tbl_key [DEPTH];
    logic [47:0] tbl_src_mac [DEPTH];
    logic [47:0] tbl_dst_mac [DEPTH];
    logic [31:0] tbl_count [DEPTH];
    int          tbl_used;

    fpc_pkg::t_out_word expected_words[$];
    int errors = 0;
    int frames_sent = 0;
    int reads_sent = 0;
    int words_checked = 0;
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    bit recv_hold = 1'b0;

    function automatic fpc_pkg::t_out_word slot_word(logic rk, logic [2:0] st, int s);
        fpc_pkg::t_out_word w;
        w.result_kind = rk;
        w.status = st;
        w.entry_index = s[5:0];
        w.src_mac = tbl_src_mac[s];
        w.dst_mac = tbl_dst_mac[s];
        w.src_ip = tbl_key[s][63:32];
        w.dst_ip = tbl_key[s][31:0];
        w.hit_count = tbl_count[s];
        return w;
    endfunction

    // work out the word a frame end gives and update the table
    task automatic close_frame();
        fpc_pkg::t_out_word w;
        logic [63:0] key;
        int hit;
        w = '0;
        hit = -1;
        key = {cur_src_ip, cur_dst_ip};
        if (pos_q < fpc_pkg::SHORT_LIMIT) begin
            w.status = fpc_pkg::ST_SHORT;
        end else begin
            for (int s = 0; s < DEPTH; s++)
                if (hit < 0 && tbl_valid[s] && tbl_key[s] == key) hit = s;
            if (hit >= 0) begin
                if (tbl_count[hit] != fpc_pkg::COUNT_MAX) tbl_count[hit]++;
                w = slot_word(fpc_pkg::KIND_FRAME, fpc_pkg::ST_HIT, hit);
            end else if (tbl_used >= DEPTH) begin
                w.status = fpc_pkg::ST_FULL;
                w.src_mac = cur_src_mac;
                w.dst_mac = cur_dst_mac;
                w.src_ip = cur_src_ip;
                w.dst_ip = cur_dst_ip;
            end else begin
                tbl_valid[tbl_used] = 1'b1;
                tbl_key[tbl_used] = key;
                tbl_src_mac[tbl_used] = cur_src_mac;
                tbl_dst_mac[tbl_used] = cur_dst_mac;
                tbl_count[tbl_used] = 32'd1;
                w = slot_word(fpc_pkg::KIND_FRAME, fpc_pkg::ST_NEW, tbl_used);
                tbl_used++;
            end
        end
        expected_words.push_back(w);
    endtask

    // predict one accepted word
    task automatic predict_word(fpc_pkg::t_in_word iw);
        fpc_pkg::t_out_word w;
        if (iw.kind == fpc_pkg::KIND_READ) begin
            reads_sent++;
            if (tbl_valid[iw.read_index]) begin
                w = slot_word(fpc_pkg::KIND_READ, fpc_pkg::ST_READ_OK, iw.read_index);
            end else begin
                w = '0;
                w.result_kind = fpc_pkg::KIND_READ;
                w.status = fpc_pkg::ST_READ_EMPTY;
                w.entry_index = iw.read_index;
            end
            expected_words.push_back(w);
            return;
        end
        if (pos_q < 6) cur_dst_mac = {cur_dst_mac[39:0], iw.frame_byte};
        else if (pos_q < 12) cur_src_mac = {cur_src_mac[39:0], iw.frame_byte};
        else if (pos_q >= 26 && pos_q < 30) cur_src_ip = {cur_src_ip[23:0], iw.frame_byte};
        else if (pos_q >= 30 && pos_q < 34) cur_dst_ip = {cur_dst_ip[23:0], iw.frame_byte};
        if (iw.frame_last) begin
            frames_sent++;
            close_frame();
            pos_q = '0;
        end else if (pos_q < fpc_pkg::POS_MAX) begin
            pos_q++;
        end
    endtask

    task automatic report(string what, fpc_pkg::t_out_word got, fpc_pkg::t_out_word exp_w);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp_w, $realtime);
    endtask

    // send one word, with random idle bursts before it
    task automatic send_word(fpc_pkg::t_in_word iw);
        if (send_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= iw;
        do @(posedge i_clk); while (!o_in_ready);
        predict_word(iw);
    endtask

    // receiver ready pattern
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (recv_hold) begin
                i_out_ready <= 1'b0;
                @(posedge i_clk);
            end else if (recv_idle && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report("unexpected word", o_out_word, '0);
            end else begin
                fpc_pkg::t_out_word e;
                e = expected_words.pop_front();
                words_checked++;
                if (o_out_word.result_kind !== e.result_kind) report("result_kind", o_out_word, e);
                if (o_out_word.status !== e.status) report("status", o_out_word, e);
                if (o_out_word.entry_index !== e.entry_index) report("entry_index", o_out_word, e);
                if (o_out_word.src_mac !== e.src_mac) report("src_mac", o_out_word, e);
                if (o_out_word.dst_mac !== e.dst_mac) report("dst_mac", o_out_word, e);
                if (o_out_word.src_ip !== e.src_ip) report("src_ip", o_out_word, e);
                if (o_out_word.dst_ip !== e.dst_ip) report("dst_ip", o_out_word, e);
                if (o_out_word.hit_count !== e.hit_count) report("hit_count", o_out_word, e);
            end
        end
    end

    // send a whole frame of given length with the given header fields
    task automatic send_frame(int len, logic [47:0] dmac, logic [47:0] smac,
                              logic [31:0] sip, logic [31:0] dip, bit mix_reads);
        fpc_pkg::t_in_word iw;
        for (int i = 0; i < len; i++) begin
            iw = '0;
            iw.kind = fpc_pkg::KIND_FRAME;
            iw.read_index = 6'($urandom);
            if (i < 6) iw.frame_byte = dmac[47 - 8*i -: 8];
            else if (i < 12) iw.frame_byte = smac[47 - 8*(i-6) -: 8];
            else if (i >= 26 && i < 30) iw.frame_byte = sip[31 - 8*(i-26) -: 8];
            else if (i >= 30 && i < 34) iw.frame_byte = dip[31 - 8*(i-30) -: 8];
            else iw.frame_byte = 8'($urandom);
            iw.frame_last = (i == len - 1);
            send_word(iw);
            if (mix_reads && $urandom_range(0, 40) == 0) send_read(6'($urandom));
        end
    endtask

    task automatic send_read(logic [5:0] idx);
        fpc_pkg::t_in_word iw;
        iw = '0;
        iw.kind = fpc_pkg::KIND_READ;
        iw.read_index = idx;
        iw.frame_byte = 8'($urandom);
        iw.frame_last = 1'($urandom);
        send_word(iw);
    endtask

    // short, exact, long frames, hit, empty reads, random reads mixed into a frame
    task automatic test_directed();
        send_read(6'd0);
        send_read(6'd63);
        send_frame(1, '1, '1, '1, '1, 0);
        send_frame(33, '1, '1, '1, '1, 0);
        send_frame(34, '1, '1, '1, '1, 0);
        send_frame(34, '1, '1, '1, '1, 0);
        send_frame(80, '0, '0, '0, '0, 0);
        send_frame(40, 48'h0102_0304_0506, 48'hA0B0_C0D0_E0F0, 32'h8000_0001,
                   32'h0000_8001, 1);
        send_read(6'd0);
        send_read(6'd2);
        send_read(6'd3);
    endtask

    // random frames drawn from a small pool of pairs, plus noise
    task automatic test_random(int n_frames);
        logic [31:0] ips [8];
        for (int i = 0; i < 8; i++) ips[i] = $urandom;
        for (int f = 0; f < n_frames; f++) begin
            case ($urandom_range(0, 9))
                0: send_frame($urandom_range(1, 33), {$urandom, 16'($urandom)},
                              {$urandom, 16'($urandom)}, $urandom, $urandom, 1);
                1: send_read(6'($urandom));
                2: send_frame($urandom_range(34, 70), {$urandom, 16'($urandom)},
                              {$urandom, 16'($urandom)}, $urandom, $urandom, 1);
                default: send_frame($urandom_range(34, 36), {$urandom, 16'($urandom)},
                              {$urandom, 16'($urandom)}, ips[$urandom_range(0, 7)],
                              ips[$urandom_range(0, 7)], 1);
            endcase
        end
    endtask

    // receiver stalls long while frames keep coming
    task automatic test_back_pressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            test_random(6);
        join
    endtask

    // add a batch of fresh pairs, then read every slot
    task automatic test_table_reads();
        for (int i = 0; i < 12; i++)
            send_frame(34, {$urandom, 16'($urandom)}, {$urandom, 16'($urandom)},
                       32'hC0A8_0000 + i, 32'h0A00_0000 + i, 0);
        for (int i = 0; i < DEPTH; i++) send_read(i[5:0]);
    endtask

    // no idling at all at the end
    task automatic test_full_rate();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        test_random(8);
    endtask

    initial begin
        int wait_cycles;
        for (int s = 0; s < DEPTH; s++) tbl_valid[s] = 1'b0;
        tbl_used = 0;
        pos_q = '0;
        cur_dst_mac = '0;
        cur_src_mac = '0;
        cur_src_ip = '0;
        cur_dst_ip = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(8);
        test_back_pressure();
        test_table_reads();
        test_full_rate();
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_words.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LAT) @(posedge i_clk);
        $display("covered %0d frames and %0d reads, %0d result words checked",
                 frames_sent, reads_sent, words_checked);
        $display("table held %0d pairs; short, long, repeated-pair and mid-frame reads seen",
                 tbl_used);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("ip_pair_flow_counter_core verification clean");
        end else begin
            $display("ip_pair_flow_counter_core verification failed");
        end
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("ip_pair_flow_counter_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/fpc_pkg.sv
design/fpc_capture.sv
design/fpc_cell.sv
design/ip_pair_flow_counter_core.sv
tb/tb_ip_pair_flow_counter_core.sv
